/* sv/pld_pkg.sv */
// Shared constants and types for the path loop detector.
`default_nettype none
package pld_pkg;

  localparam int DEF_POINT_DEPTH = 256;
  localparam int DEF_MAX_LOOPS   = 32;
  localparam int DEF_COORD_WIDTH = 24;

  localparam int CW_LIMIT    = 30;
  localparam int TABLE_LIMIT = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int DIGIT_W     = 16;
  localparam int QUOT_BITS   = 16;
  localparam int T_SHIFT     = 16;
  localparam int PAR_LIMIT   = 512;
  localparam int IDX_W       = 8;
  localparam int MID_W       = 24;
  localparam int PRUNE_W     = 16;

  localparam logic [PRUNE_W-1:0] PRUNE_RESET = 16'd256;

  typedef struct packed {
    logic loop_valid;
    logic table_full;
    logic points_dropped;
    logic last_result;
  } res_flags_t;

endpackage
`default_nettype wire

/* sv/path_loop_detector.sv */
// Top level of the path loop detector: input queue, scan engine and configuration port.
// Points are taken one per cycle into a 256-entry (POINT_DEPTH) point memory while the
// block is loading; the point marked last starts a scan over non-adjacent segment
// pairs, during which input is stalled. For each pair the memory gives one point a
// cycle, the five dot products share one small multiplier and the determinant terms go
// through a multiplier that takes a 16-bit digit a cycle; a pair not rejected as nearly
// parallel gets its line parameters from a divider that makes one quotient bit a cycle
// and its distance squares from the digit multiplier. Loops are kept in a table of
// up to min(MAX_LOOPS,32) entries and, once the scan ends, leave through the output
// register at one transfer a cycle while out_stall is low; a scan that finds none gives
// one result with loop_valid low. The next path may start loading while the last result
// still waits in the output register. prune_distance resets to 256 and the user must
// write it through the configuration port while the block is idle; no check enforces it.
`default_nettype none
module path_loop_detector #(
  parameter int POINT_DEPTH = pld_pkg::DEF_POINT_DEPTH,
  parameter int MAX_LOOPS   = pld_pkg::DEF_MAX_LOOPS,
  parameter int COORD_WIDTH = pld_pkg::DEF_COORD_WIDTH
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [pld_pkg::PRUNE_W-1:0]  cfg_data,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire signed [COORD_WIDTH-1:0] in_point_x,
  input  wire signed [COORD_WIDTH-1:0] in_point_y,
  input  wire signed [COORD_WIDTH-1:0] in_point_z,
  input  wire                          in_is_last_point,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [pld_pkg::IDX_W-1:0]    out_loop_start,
  output logic [pld_pkg::IDX_W-1:0]    out_loop_end,
  output logic signed [pld_pkg::MID_W-1:0] out_mid_x,
  output logic signed [pld_pkg::MID_W-1:0] out_mid_y,
  output logic signed [pld_pkg::MID_W-1:0] out_mid_z,
  output logic                         out_loop_valid,
  output logic                         out_table_full,
  output logic                         out_points_dropped,
  output logic                         out_last_result
);

  localparam int CW = (COORD_WIDTH > pld_pkg::CW_LIMIT) ? pld_pkg::CW_LIMIT : COORD_WIDTH;

  logic                q_valid, q_pop, q_last;
  logic signed [CW-1:0] q_x, q_y, q_z;
  pld_pkg::res_flags_t flags;

  assign cfg_ready = 1'b1;

  pld_front #(.COORD_WIDTH(COORD_WIDTH), .CW(CW)) u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .in_point_z       (in_point_z),
    .in_is_last_point (in_is_last_point),
    .q_valid          (q_valid),
    .q_pop            (q_pop),
    .q_x              (q_x),
    .q_y              (q_y),
    .q_z              (q_z),
    .q_last           (q_last)
  );

  pld_back #(.POINT_DEPTH(POINT_DEPTH), .MAX_LOOPS(MAX_LOOPS), .CW(CW)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid && cfg_ready),
    .cfg_data       (cfg_data),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_x            (q_x),
    .q_y            (q_y),
    .q_z            (q_z),
    .q_last         (q_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_loop_start (out_loop_start),
    .out_loop_end   (out_loop_end),
    .out_mid_x      (out_mid_x),
    .out_mid_y      (out_mid_y),
    .out_mid_z      (out_mid_z),
    .out_flags      (flags)
  );

  assign out_loop_valid     = flags.loop_valid;
  assign out_table_full     = flags.table_full;
  assign out_points_dropped = flags.points_dropped;
  assign out_last_result    = flags.last_result;

  // A result without a loop is always the only, and so the last, one of its scan.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_loop_valid |-> out_last_result)
    else $error("result without a loop is not marked last");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_loop_valid |-> out_loop_start == '0 && out_loop_end == '0)
    else $error("result without a loop carries indexes");

  a_full_has_loop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_table_full |-> out_loop_valid)
    else $error("table full flagged on a result without a loop");

  a_loop_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_loop_valid && out_loop_start != '0 |-> out_loop_end != out_loop_start)
    else $error("loop ends where it starts");

endmodule
`default_nettype wire

/* sv/pld_front.sv */
// Input side: accepts points, trims coordinates and queues them for the scan engine.
`default_nettype none
module pld_front #(
  parameter int COORD_WIDTH = pld_pkg::DEF_COORD_WIDTH,
  parameter int CW          = pld_pkg::DEF_COORD_WIDTH
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire signed [COORD_WIDTH-1:0] in_point_x,
  input  wire signed [COORD_WIDTH-1:0] in_point_y,
  input  wire signed [COORD_WIDTH-1:0] in_point_z,
  input  wire                          in_is_last_point,
  output logic                         q_valid,
  input  wire                          q_pop,
  output logic signed [CW-1:0]         q_x,
  output logic signed [CW-1:0]         q_y,
  output logic signed [CW-1:0]         q_z,
  output logic                         q_last
);

  localparam int QD  = pld_pkg::QUEUE_DEPTH;
  localparam int QAW = (QD > 1) ? $clog2(QD) : 1;
  localparam int QCW = $clog2(QD + 1);

  logic signed [CW-1:0] x_r [QD];
  logic signed [CW-1:0] y_r [QD];
  logic signed [CW-1:0] z_r [QD];
  logic                 last_r [QD];
  logic [QAW-1:0]       wp_r, rp_r;
  logic [QCW-1:0]       cnt_r;
  logic                 push;

  assign in_stall = (cnt_r == QCW'(QD));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_x      = x_r[rp_r];
  assign q_y      = y_r[rp_r];
  assign q_z      = z_r[rp_r];
  assign q_last   = last_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == QAW'(QD - 1)) ? '0 : wp_r + 1'b1;
      end
      if (q_pop) begin
        rp_r <= (rp_r == QAW'(QD - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // Only the low CW bits of a coordinate carry meaning.
  always_ff @(posedge clk) begin
    if (push) begin
      x_r[wp_r]    <= in_point_x[CW-1:0];
      y_r[wp_r]    <= in_point_y[CW-1:0];
      z_r[wp_r]    <= in_point_z[CW-1:0];
      last_r[wp_r] <= in_is_last_point;
    end
  end

endmodule
`default_nettype wire

/* sv/pld_mul.sv */
// Multi-cycle signed multiplier that works through one 16-bit digit of the second operand a cycle.
`default_nettype none
module pld_mul #(
  parameter int W = 52
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  wire signed [W-1:0]  a,
  input  wire signed [W-1:0]  b,
  output logic                done,
  output logic signed [2*W-1:0] p
);

  localparam int DG  = pld_pkg::DIGIT_W;
  localparam int ND  = (W + DG - 1) / DG;
  localparam int BW  = ND * DG;
  localparam int AW2 = W + BW;
  localparam int CNW = $clog2(ND + 1);

  logic [W-1:0]    ma_r;
  logic [BW-1:0]   mb_r;
  logic [AW2-1:0]  acc_r;
  logic [CNW-1:0]  cnt_r;
  logic            neg_r;
  logic            done_r;
  logic [W-1:0]    a_mag, b_mag;
  logic [W+DG-1:0] pp;

  assign a_mag = a[W-1] ? (~a + 1'b1) : a;
  assign b_mag = b[W-1] ? (~b + 1'b1) : b;
  assign pp    = ma_r * mb_r[BW-1 -: DG];
  assign done  = done_r;
  assign p     = neg_r ? (~acc_r[2*W-1:0] + 1'b1) : acc_r[2*W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        cnt_r <= CNW'(ND);
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  // Most significant digit first, so the accumulator only ever shifts left.
  always_ff @(posedge clk) begin
    if (start) begin
      ma_r  <= a_mag;
      mb_r  <= BW'(b_mag);
      acc_r <= '0;
      neg_r <= a[W-1] ^ b[W-1];
    end else if (cnt_r != '0) begin
      acc_r <= (acc_r << DG) + AW2'(pp);
      mb_r  <= mb_r << DG;
    end
  end

endmodule
`default_nettype wire

/* sv/pld_div.sv */
// Restoring divider giving a line parameter clamped to [0,1] in Q1.16, one quotient bit a cycle.
`default_nettype none
module pld_div #(
  parameter int W = 106
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  input  wire signed [W-1:0]  num,
  input  wire signed [W-1:0]  den,
  output logic                done,
  output logic [pld_pkg::QUOT_BITS:0] quot
);

  localparam int QB  = pld_pkg::QUOT_BITS;
  localparam int CNW = $clog2(QB + 1);

  logic [W-1:0]   rem_r, dv_r;
  logic [QB:0]    q_r;
  logic [CNW-1:0] cnt_r;
  logic           done_r;
  logic [W:0]     rem2;
  logic [W:0]     diff;
  logic           ge;

  assign rem2 = {rem_r, 1'b0};
  assign diff = rem2 - {1'b0, dv_r};
  assign ge   = (rem2 >= {1'b0, dv_r});
  assign done = done_r;
  assign quot = q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        // Clamped cases finish at once.
        if (num[W-1] || (num == '0) || (num >= den)) begin
          cnt_r  <= '0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= CNW'(QB);
        end
      end else if (cnt_r != '0) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNW'(1)) begin
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dv_r  <= den;
      if (num[W-1] || (num == '0)) begin
        q_r <= '0;
      end else if (num >= den) begin
        q_r <= {1'b1, QB'(0)};
      end else begin
        q_r <= '0;
      end
    end else if (cnt_r != '0) begin
      if (ge) begin
        rem_r <= diff[W-1:0];
        q_r   <= {q_r[QB-1:0], 1'b1};
      end else begin
        rem_r <= rem2[W-1:0];
        q_r   <= {q_r[QB-1:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

/* sv/pld_back.sv */
// Scan engine: point memory, segment pair sequencer, loop table and result register.
`default_nettype none
module pld_back #(
  parameter int POINT_DEPTH = pld_pkg::DEF_POINT_DEPTH,
  parameter int MAX_LOOPS   = pld_pkg::DEF_MAX_LOOPS,
  parameter int CW          = pld_pkg::DEF_COORD_WIDTH
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_valid,
  input  wire  [pld_pkg::PRUNE_W-1:0]        cfg_data,
  input  wire                                q_valid,
  output logic                               q_pop,
  input  wire  signed [CW-1:0]               q_x,
  input  wire  signed [CW-1:0]               q_y,
  input  wire  signed [CW-1:0]               q_z,
  input  wire                                q_last,
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic [pld_pkg::IDX_W-1:0]          out_loop_start,
  output logic [pld_pkg::IDX_W-1:0]          out_loop_end,
  output logic signed [pld_pkg::MID_W-1:0]   out_mid_x,
  output logic signed [pld_pkg::MID_W-1:0]   out_mid_y,
  output logic signed [pld_pkg::MID_W-1:0]   out_mid_z,
  output pld_pkg::res_flags_t                out_flags
);

  localparam int AW       = $clog2(POINT_DEPTH);
  localparam int CNTW     = $clog2(POINT_DEPTH + 1);
  localparam int IXW      = (CNTW + 1 > pld_pkg::IDX_W) ? CNTW + 1 : pld_pkg::IDX_W;
  localparam int LOOP_CAP = (MAX_LOOPS < pld_pkg::TABLE_LIMIT) ? MAX_LOOPS
                                                                : pld_pkg::TABLE_LIMIT;
  localparam int TIW      = (LOOP_CAP > 1) ? $clog2(LOOP_CAP) : 1;
  localparam int NLW      = $clog2(LOOP_CAP + 1);
  localparam int DW       = CW + 1;
  localparam int PW       = 2 * DW + 2;
  localparam int TQW      = pld_pkg::QUOT_BITS + 1;
  localparam int MPW      = DW + TQW + 1;
  localparam int DPW      = DW + 19;
  localparam int MW       = (PW > DPW) ? PW : DPW;
  localparam int WW       = 2 * PW + 2;
  localparam int DSW      = 2 * DPW + 2;
  localparam int MIDW     = (CW + 20 > 41) ? CW + 20 : 41;
  localparam int MW24     = pld_pkg::MID_W;
  localparam int IW       = pld_pkg::IDX_W;
  localparam int ENTW     = 2 * IW + 3 * MW24;

  localparam logic [2:0] DOT_A = 3'd0;
  localparam logic [2:0] DOT_B = 3'd1;
  localparam logic [2:0] DOT_C = 3'd2;
  localparam logic [2:0] DOT_D = 3'd3;
  localparam logic [2:0] DOT_E = 3'd4;

  localparam logic [2:0] PR_AC = 3'd0;
  localparam logic [2:0] PR_BB = 3'd1;
  localparam logic [2:0] PR_BE = 3'd2;
  localparam logic [2:0] PR_CD = 3'd3;
  localparam logic [2:0] PR_AE = 3'd4;
  localparam logic [2:0] PR_BD = 3'd5;

  localparam logic [1:0] WIDE_DEN = 2'd0;
  localparam logic [1:0] WIDE_N1  = 2'd1;
  localparam logic [1:0] WIDE_N2  = 2'd2;

  localparam logic signed [MIDW-1:0] MID_HALF = MIDW'(1) <<< pld_pkg::T_SHIFT;
  localparam logic signed [WW-1:0]   DEN_MIN  = WW'(pld_pkg::PAR_LIMIT);

  typedef enum logic [4:0] {
    S_LOAD, S_OUTER, S_INNER, S_RD0, S_RD1, S_RD2, S_RD3, S_RD4, S_DIFF,
    S_DOTM, S_DOTA, S_WMUL, S_WWAIT, S_PAR, S_DIV1, S_DIV1W, S_DIV2, S_DIV2W,
    S_DP0, S_DP1, S_DP2, S_DPW, S_CMP, S_EMIT
  } state_t;

  state_t state_r;

  logic [CNTW-1:0] cnt_r, i_r, j_r, minp_r;
  logic            ovf_r, full_r;
  logic [NLW-1:0]  nl_r, ek_r;
  logic [pld_pkg::PRUNE_W-1:0] pd_r;
  logic [2*pld_pkg::PRUNE_W-1:0] thr_r;

  logic [3*CW-1:0] mem [POINT_DEPTH];
  logic [3*CW-1:0] rdata_r;
  logic [AW-1:0]   rd_addr;

  logic signed [CW-1:0]   pt_r [4][3];
  logic signed [DW-1:0]   l1_r [3];
  logic signed [DW-1:0]   l2_r [3];
  logic signed [DW-1:0]   sd_r [3];
  logic [2:0]             dq_r;
  logic [1:0]             dk_r;
  logic signed [2*DW-1:0] sprod_r;
  logic signed [PW-1:0]   dot_r [5];
  logic [2:0]             wi_r;
  logic signed [WW-1:0]   wide_r [3];
  logic [TQW-1:0]         t1_r, t2_r;
  logic signed [MPW-1:0]  m1_r, m2_r;
  logic signed [DPW-1:0]  dp_r;
  logic [DSW-1:0]         dist_r;
  logic [MW24-1:0]        mid_r [3];
  logic [ENTW-1:0]        table_r [LOOP_CAP];

  logic                   out_valid_r;
  logic [IW-1:0]          out_ls_r, out_le_r;
  logic [MW24-1:0]        out_mx_r, out_my_r, out_mz_r;
  pld_pkg::res_flags_t    flags_r;

  logic [CNTW:0]          i_plus1, i_plus2, j_plus1;
  logic [CNTW-1:0]        j_start;
  logic [IXW-1:0]         ls_w, le_w;
  logic signed [DW-1:0]   ox, oy;
  logic signed [MW-1:0]   mul_a, mul_b;
  logic                   mul_start, mul_done;
  logic signed [2*MW-1:0] mul_p;
  logic                   div_start, div_done;
  logic signed [WW-1:0]   div_num;
  logic [TQW-1:0]         div_q;
  logic signed [MIDW-1:0] mid_sum;
  logic signed [MIDW-1:0] mid_sh;
  logic                   match;
  logic                   tbl_we;
  logic [ENTW-1:0]        ent;
  logic                   emit_go;
  logic                   ent_last;

  assign i_plus1 = (CNTW + 1)'(i_r) + 1'b1;
  assign i_plus2 = (CNTW + 1)'(i_r) + (CNTW + 1)'(2);
  assign j_plus1 = (CNTW + 1)'(j_r) + 1'b1;
  assign j_start = (i_plus2 > {1'b0, minp_r}) ? i_plus2[CNTW-1:0] : minp_r;
  assign ls_w    = IXW'(i_plus1);
  assign le_w    = IXW'(j_plus1);

  assign q_pop   = (state_r == S_LOAD) && q_valid;
  assign match   = (dist_r <= DSW'({thr_r, 32'd0}));
  assign tbl_we  = (state_r == S_CMP) && match;
  assign ent     = table_r[ek_r[TIW-1:0]];
  assign emit_go = !out_valid_r || !out_stall;
  assign ent_last = (ek_r == nl_r - 1'b1);

  always_comb begin
    case (state_r)
      S_RD0:   rd_addr = i_r[AW-1:0];
      S_RD1:   rd_addr = i_plus1[AW-1:0];
      S_RD2:   rd_addr = j_r[AW-1:0];
      S_RD3:   rd_addr = j_plus1[AW-1:0];
      default: rd_addr = '0;
    endcase
  end

  always_comb begin
    unique case (dq_r)
      DOT_A:   begin ox = l1_r[dk_r]; oy = l1_r[dk_r]; end
      DOT_B:   begin ox = l1_r[dk_r]; oy = l2_r[dk_r]; end
      DOT_C:   begin ox = l2_r[dk_r]; oy = l2_r[dk_r]; end
      DOT_D:   begin ox = l1_r[dk_r]; oy = sd_r[dk_r]; end
      default: begin ox = l2_r[dk_r]; oy = sd_r[dk_r]; end
    endcase
  end

  // The multiplier is shared between the wide determinant terms and the distance squares.
  always_comb begin
    if (state_r == S_DP2) begin
      mul_a = MW'(dp_r);
      mul_b = MW'(dp_r);
    end else begin
      unique case (wi_r)
        PR_AC:   begin mul_a = MW'(dot_r[DOT_A]); mul_b = MW'(dot_r[DOT_C]); end
        PR_BB:   begin mul_a = MW'(dot_r[DOT_B]); mul_b = MW'(dot_r[DOT_B]); end
        PR_BE:   begin mul_a = MW'(dot_r[DOT_B]); mul_b = MW'(dot_r[DOT_E]); end
        PR_CD:   begin mul_a = MW'(dot_r[DOT_C]); mul_b = MW'(dot_r[DOT_D]); end
        PR_AE:   begin mul_a = MW'(dot_r[DOT_A]); mul_b = MW'(dot_r[DOT_E]); end
        default: begin mul_a = MW'(dot_r[DOT_B]); mul_b = MW'(dot_r[DOT_D]); end
      endcase
    end
  end

  assign mul_start = (state_r == S_WMUL) || (state_r == S_DP2);
  assign div_start = (state_r == S_DIV1) || (state_r == S_DIV2);
  assign div_num   = (state_r == S_DIV2) ? wide_r[WIDE_N2] : wide_r[WIDE_N1];

  // Midpoint rounds to nearest with ties upward: add one half, then floor.
  always_comb begin
    mid_sum = ((MIDW'(pt_r[0][dk_r]) + MIDW'(pt_r[2][dk_r])) <<< pld_pkg::T_SHIFT)
              + MIDW'(m1_r) + MIDW'(m2_r) + MID_HALF;
    mid_sh  = mid_sum >>> (pld_pkg::T_SHIFT + 1);
  end

  pld_mul #(.W(MW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  pld_div #(.W(WW)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (wide_r[WIDE_DEN]),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (q_pop && (cnt_r < CNTW'(POINT_DEPTH))) begin
      mem[cnt_r[AW-1:0]] <= {q_x, q_y, q_z};
    end
    rdata_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      table_r[nl_r[TIW-1:0]] <= {ls_w[IW-1:0], le_w[IW-1:0], mid_r[0], mid_r[1], mid_r[2]};
    end
  end

  always_ff @(posedge clk) begin
    thr_r <= pd_r * pd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      i_r         <= '0;
      j_r         <= '0;
      minp_r      <= CNTW'(2);
      nl_r        <= '0;
      full_r      <= 1'b0;
      ek_r        <= '0;
      dq_r        <= '0;
      dk_r        <= '0;
      wi_r        <= '0;
      out_valid_r <= 1'b0;
      pd_r        <= pld_pkg::PRUNE_RESET;
    end else begin
      if (cfg_valid) begin
        pd_r <= cfg_data;
      end
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_LOAD: begin
          if (q_valid) begin
            if (cnt_r < CNTW'(POINT_DEPTH)) begin
              cnt_r <= cnt_r + 1'b1;
            end else begin
              ovf_r <= 1'b1;
            end
            if (q_last) begin
              i_r     <= '0;
              minp_r  <= CNTW'(2);
              nl_r    <= '0;
              full_r  <= 1'b0;
              state_r <= S_OUTER;
            end
          end
        end
        S_OUTER: begin
          if (!full_r && (i_plus2 < {1'b0, cnt_r})) begin
            j_r     <= j_start;
            state_r <= S_INNER;
          end else begin
            ek_r    <= '0;
            state_r <= S_EMIT;
          end
        end
        S_INNER: begin
          if (j_plus1 < {1'b0, cnt_r}) begin
            state_r <= S_RD0;
          end else begin
            i_r     <= i_plus1[CNTW-1:0];
            state_r <= S_OUTER;
          end
        end
        S_RD0: state_r <= S_RD1;
        S_RD1: begin
          pt_r[0][0] <= rdata_r[3*CW-1:2*CW];
          pt_r[0][1] <= rdata_r[2*CW-1:CW];
          pt_r[0][2] <= rdata_r[CW-1:0];
          state_r    <= S_RD2;
        end
        S_RD2: begin
          pt_r[1][0] <= rdata_r[3*CW-1:2*CW];
          pt_r[1][1] <= rdata_r[2*CW-1:CW];
          pt_r[1][2] <= rdata_r[CW-1:0];
          state_r    <= S_RD3;
        end
        S_RD3: begin
          pt_r[2][0] <= rdata_r[3*CW-1:2*CW];
          pt_r[2][1] <= rdata_r[2*CW-1:CW];
          pt_r[2][2] <= rdata_r[CW-1:0];
          state_r    <= S_RD4;
        end
        S_RD4: begin
          pt_r[3][0] <= rdata_r[3*CW-1:2*CW];
          pt_r[3][1] <= rdata_r[2*CW-1:CW];
          pt_r[3][2] <= rdata_r[CW-1:0];
          state_r    <= S_DIFF;
        end
        S_DIFF: begin
          for (int k = 0; k < 3; k++) begin
            l1_r[k] <= DW'(pt_r[1][k]) - DW'(pt_r[0][k]);
            l2_r[k] <= DW'(pt_r[3][k]) - DW'(pt_r[2][k]);
            sd_r[k] <= DW'(pt_r[0][k]) - DW'(pt_r[2][k]);
          end
          for (int k = 0; k < 5; k++) begin
            dot_r[k] <= '0;
          end
          dq_r    <= DOT_A;
          dk_r    <= '0;
          state_r <= S_DOTM;
        end
        S_DOTM: begin
          sprod_r <= ox * oy;
          state_r <= S_DOTA;
        end
        S_DOTA: begin
          dot_r[dq_r] <= dot_r[dq_r] + PW'(sprod_r);
          if (dk_r == 2'd2) begin
            dk_r <= '0;
            dq_r <= dq_r + 1'b1;
            if (dq_r == DOT_E) begin
              wi_r <= PR_AC;
              for (int k = 0; k < 3; k++) begin
                wide_r[k] <= '0;
              end
              state_r <= S_WMUL;
            end else begin
              state_r <= S_DOTM;
            end
          end else begin
            dk_r    <= dk_r + 1'b1;
            state_r <= S_DOTM;
          end
        end
        S_WMUL: state_r <= S_WWAIT;
        S_WWAIT: begin
          if (mul_done) begin
            // Odd product numbers are the subtracted terms.
            if (wi_r[0]) begin
              wide_r[wi_r[2:1]] <= wide_r[wi_r[2:1]] - WW'(mul_p);
            end else begin
              wide_r[wi_r[2:1]] <= wide_r[wi_r[2:1]] + WW'(mul_p);
            end
            wi_r <= wi_r + 1'b1;
            state_r <= (wi_r == PR_BD) ? S_PAR : S_WMUL;
          end
        end
        S_PAR: begin
          if (wide_r[WIDE_DEN] < DEN_MIN) begin
            j_r     <= j_plus1[CNTW-1:0];
            state_r <= S_INNER;
          end else begin
            state_r <= S_DIV1;
          end
        end
        S_DIV1: state_r <= S_DIV1W;
        S_DIV1W: begin
          if (div_done) begin
            t1_r    <= div_q;
            state_r <= S_DIV2;
          end
        end
        S_DIV2: state_r <= S_DIV2W;
        S_DIV2W: begin
          if (div_done) begin
            t2_r    <= div_q;
            dk_r    <= '0;
            dist_r  <= '0;
            state_r <= S_DP0;
          end
        end
        S_DP0: begin
          m1_r    <= MPW'(l1_r[dk_r]) * MPW'($signed({1'b0, t1_r}));
          m2_r    <= MPW'(l2_r[dk_r]) * MPW'($signed({1'b0, t2_r}));
          state_r <= S_DP1;
        end
        S_DP1: begin
          dp_r <= (DPW'(sd_r[dk_r]) <<< pld_pkg::T_SHIFT) + DPW'(m1_r) - DPW'(m2_r);
          mid_r[dk_r] <= mid_sh[MW24-1:0];
          state_r <= S_DP2;
        end
        S_DP2: state_r <= S_DPW;
        S_DPW: begin
          if (mul_done) begin
            dist_r <= dist_r + DSW'($unsigned(mul_p));
            if (dk_r == 2'd2) begin
              state_r <= S_CMP;
            end else begin
              dk_r    <= dk_r + 1'b1;
              state_r <= S_DP0;
            end
          end
        end
        S_CMP: begin
          if (match) begin
            minp_r <= j_r;
            nl_r   <= nl_r + 1'b1;
            if (nl_r + 1'b1 == NLW'(LOOP_CAP)) begin
              full_r  <= 1'b1;
              ek_r    <= '0;
              state_r <= S_EMIT;
            end else begin
              j_r     <= j_plus1[CNTW-1:0];
              state_r <= S_INNER;
            end
          end else begin
            j_r     <= j_plus1[CNTW-1:0];
            state_r <= S_INNER;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_valid_r <= 1'b1;
            if (nl_r == '0) begin
              out_ls_r <= '0;
              out_le_r <= '0;
              out_mx_r <= '0;
              out_my_r <= '0;
              out_mz_r <= '0;
              flags_r  <= '{loop_valid: 1'b0, table_full: 1'b0,
                             points_dropped: ovf_r, last_result: 1'b1};
              cnt_r    <= '0;
              ovf_r    <= 1'b0;
              state_r  <= S_LOAD;
            end else begin
              {out_ls_r, out_le_r, out_mx_r, out_my_r, out_mz_r} <= ent;
              flags_r <= '{loop_valid: 1'b1, table_full: full_r,
                           points_dropped: ovf_r, last_result: ent_last};
              if (ent_last) begin
                cnt_r   <= '0;
                ovf_r   <= 1'b0;
                state_r <= S_LOAD;
              end else begin
                ek_r <= ek_r + 1'b1;
              end
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_loop_start = out_ls_r;
  assign out_loop_end   = out_le_r;
  assign out_mid_x      = out_mx_r;
  assign out_mid_y      = out_my_r;
  assign out_mid_z      = out_mz_r;
  assign out_flags      = flags_r;

endmodule
`default_nettype wire

/* sim/pld_loop_checker.sv */
// Checker for the path loop detector: predicts every scan's loop list and compares results.
`timescale 1ns / 1ps
`default_nettype none
module pld_loop_checker (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_valid,
  input  wire               cfg_ready,
  input  wire [15:0]        cfg_data,
  input  wire               in_valid,
  input  wire               in_stall,
  input  wire signed [23:0] in_point_x,
  input  wire signed [23:0] in_point_y,
  input  wire signed [23:0] in_point_z,
  input  wire               in_is_last_point,
  input  wire               out_valid,
  input  wire               out_stall,
  input  wire [7:0]         out_loop_start,
  input  wire [7:0]         out_loop_end,
  input  wire [23:0]        out_mid_x,
  input  wire [23:0]        out_mid_y,
  input  wire [23:0]        out_mid_z,
  input  wire               out_loop_valid,
  input  wire               out_table_full,
  input  wire               out_points_dropped,
  input  wire               out_last_result,
  output int                fail_count,
  output int                loops_due_count,
  output int                results_seen
);
  import pld_pkg::*;

  localparam int DEPTH = 256;
  localparam int CAP   = 32;

  typedef logic signed [127:0] wide_t;

  typedef struct packed {
    logic [7:0]  lp_start;
    logic [7:0]  lp_end;
    logic [23:0] mx;
    logic [23:0] my;
    logic [23:0] mz;
    res_flags_t  flags;
  } loop_rec_t;

  longint    pts [DEPTH][3];
  int        pt_count;
  bit        dropped;
  logic [15:0] prune;
  loop_rec_t loops_due [$];
  int        fails;
  int        seen;

  // Line parameter as Q1.16, clamped to [0,1]; den is known positive.
  function automatic longint line_param(wide_t num, wide_t den);
    if (num <= 0) return 0;
    if (num >= den) return 65536;
    return longint'((num <<< 16) / den);
  endfunction

  function automatic bit pair_meets(int i, int j, output longint mid [3]);
    longint l1 [3];
    longint l2 [3];
    longint sd [3];
    longint a, b, c, d, e, t1, t2, dp, v;
    wide_t  den, n1, n2, dist2, tq;
    a = 0; b = 0; c = 0; d = 0; e = 0;
    for (int k = 0; k < 3; k++) begin
      l1[k] = pts[i+1][k] - pts[i][k];
      l2[k] = pts[j+1][k] - pts[j][k];
      sd[k] = pts[i][k] - pts[j][k];
      a += l1[k] * l1[k];
      b += l1[k] * l2[k];
      c += l2[k] * l2[k];
      d += l1[k] * sd[k];
      e += l2[k] * sd[k];
    end
    den = wide_t'(a) * wide_t'(c) - wide_t'(b) * wide_t'(b);
    if (den < wide_t'(PAR_LIMIT)) return 0;
    n1 = wide_t'(b) * wide_t'(e) - wide_t'(c) * wide_t'(d);
    n2 = wide_t'(a) * wide_t'(e) - wide_t'(b) * wide_t'(d);
    t1 = line_param(n1, den);
    t2 = line_param(n2, den);
    dist2 = 0;
    for (int k = 0; k < 3; k++) begin
      dp = sd[k] * 65536 + l1[k] * t1 - l2[k] * t2;
      dist2 += wide_t'(dp) * wide_t'(dp);
    end
    tq = wide_t'({prune, 16'h0000});
    if (dist2 > tq * tq) return 0;
    for (int k = 0; k < 3; k++) begin
      v = (pts[i][k] + pts[j][k]) * 65536 + l1[k] * t1 + l2[k] * t2;
      // Arithmetic shift gives round to nearest, ties upward.
      mid[k] = (v + 65536) >>> 17;
    end
    return 1;
  endfunction

  task automatic scan_path();
    loop_rec_t found [$];
    loop_rec_t rec;
    longint    mid [3];
    int        partner_floor, j;
    bit        full;
    partner_floor = 2;
    full = 0;
    for (int i = 0; i + 2 < pt_count && !full; i++) begin
      j = (i + 2 > partner_floor) ? i + 2 : partner_floor;
      for (; j + 1 < pt_count && !full; j++) begin
        if (pair_meets(i, j, mid)) begin
          partner_floor = j;
          rec = '0;
          rec.lp_start = 8'(i + 1);
          rec.lp_end = 8'(j + 1);
          rec.mx = 24'(mid[0]);
          rec.my = 24'(mid[1]);
          rec.mz = 24'(mid[2]);
          rec.flags.loop_valid = 1'b1;
          found.push_back(rec);
          if (found.size() >= CAP) full = 1;
        end
      end
    end
    if (found.size() == 0) begin
      rec = '0;
      found.push_back(rec);
    end
    foreach (found[k]) begin
      found[k].flags.table_full = full;
      found[k].flags.points_dropped = dropped;
      found[k].flags.last_result = (k == found.size() - 1);
      loops_due.push_back(found[k]);
    end
    pt_count = 0;
    dropped = 0;
  endtask

  always @(posedge clk) begin
    loop_rec_t got, want;
    if (!rst_n) begin
      pt_count = 0;
      dropped = 0;
      prune = PRUNE_RESET;
      loops_due.delete();
      fails = 0;
      seen = 0;
    end else begin
      if (cfg_valid && cfg_ready) prune = cfg_data;
      if (out_valid && !out_stall) begin
        got.lp_start = out_loop_start;
        got.lp_end = out_loop_end;
        got.mx = out_mid_x;
        got.my = out_mid_y;
        got.mz = out_mid_z;
        got.flags = '{out_loop_valid, out_table_full, out_points_dropped, out_last_result};
        seen++;
        if (loops_due.size() == 0) begin
          if (fails < 10) $display("ERROR: result with nothing expected: %p", got);
          fails++;
        end else begin
          want = loops_due.pop_front();
          if (got.lp_start !== want.lp_start || got.lp_end !== want.lp_end ||
              got.mx !== want.mx || got.my !== want.my || got.mz !== want.mz ||
              got.flags.loop_valid !== want.flags.loop_valid ||
              got.flags.table_full !== want.flags.table_full ||
              got.flags.points_dropped !== want.flags.points_dropped ||
              got.flags.last_result !== want.flags.last_result) begin
            if (fails < 10) $display("ERROR: loop mismatch\n  expected %p\n  actual   %p", want, got);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (pt_count < DEPTH) begin
          pts[pt_count][0] = longint'(in_point_x);
          pts[pt_count][1] = longint'(in_point_y);
          pts[pt_count][2] = longint'(in_point_z);
          pt_count++;
        end else begin
          dropped = 1;
        end
        if (in_is_last_point) scan_path();
      end
    end
    fail_count <= fails;
    loops_due_count <= loops_due.size();
    results_seen <= seen;
  end
endmodule
`default_nettype wire

/* sim/tb_path_loop_detector.sv */
// Testbench top for the path loop detector: stimulus, idling, watchdog and verdict.
`timescale 1ns / 1ps
`default_nettype none
module tb_path_loop_detector;
  localparam int IDLE_LIMIT = 300000;
  localparam int RANDOM_POINTS = 320;

  logic clk;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [15:0] cfg_data;
  logic in_valid;
  logic in_stall;
  logic signed [23:0] in_point_x, in_point_y, in_point_z;
  logic in_is_last_point;
  logic out_valid;
  logic out_stall;
  logic [7:0] out_loop_start, out_loop_end;
  logic signed [23:0] out_mid_x, out_mid_y, out_mid_z;
  logic out_loop_valid, out_table_full, out_points_dropped, out_last_result;
  int fail_count, loops_due_count, results_seen;
  int paths_sent, points_sent, settings_used, idle_cycles;
  bit calm_out;
  int stall_left;

  path_loop_detector u_top (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_data,
    .in_valid, .in_stall, .in_point_x, .in_point_y, .in_point_z, .in_is_last_point,
    .out_valid, .out_stall, .out_loop_start, .out_loop_end,
    .out_mid_x, .out_mid_y, .out_mid_z, .out_loop_valid, .out_table_full,
    .out_points_dropped, .out_last_result
  );

  pld_loop_checker u_checker (
    .clk, .rst_n, .cfg_valid, .cfg_ready, .cfg_data,
    .in_valid, .in_stall, .in_point_x, .in_point_y, .in_point_z, .in_is_last_point,
    .out_valid, .out_stall, .out_loop_start, .out_loop_end,
    .out_mid_x(out_mid_x), .out_mid_y(out_mid_y), .out_mid_z(out_mid_z),
    .out_loop_valid, .out_table_full, .out_points_dropped, .out_last_result,
    .fail_count, .loops_due_count, .results_seen
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic signed [23:0] jitter(int span);
    return 24'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  // Result side: stretches without stall alternate with random short and long stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if ($urandom_range(0, 299) == 0) calm_out <= ~calm_out;
      if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (!calm_out && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 2);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Watchdog: no transfer for %0d cycles", IDLE_LIMIT);
        $display("path_loop_detector test failed");
        $finish;
      end
    end
  end

  task automatic put_point(logic signed [23:0] x, y, z, bit last, bit quiet);
    int g;
    in_valid <= 1'b1;
    in_point_x <= x;
    in_point_y <= y;
    in_point_z <= z;
    in_is_last_point <= last;
    do @(posedge clk); while (in_stall);
    points_sent++;
    g = quiet ? 0 : pick_gap();
    // The end of a path always drops valid before the next point is offered.
    if (last && g == 0) g = 1;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Random walk; some points return near an earlier one so loops do occur.
  task automatic send_path(int len, int span, bit full_bits);
    logic signed [23:0] hx [$], hy [$], hz [$];
    logic signed [23:0] x, y, z;
    int back;
    bit quiet;
    quiet = ($urandom_range(0, 2) == 0);
    x = jitter(span); y = jitter(span); z = jitter(span);
    for (int n = 0; n < len; n++) begin
      if (full_bits) begin
        x = 24'($urandom); y = 24'($urandom); z = 24'($urandom);
      end else if (n > 2 && $urandom_range(0, 3) == 0) begin
        back = $urandom_range(0, n - 2);
        x = hx[back] + jitter(span / 8 + 1);
        y = hy[back] + jitter(span / 8 + 1);
        z = hz[back] + jitter(span / 8 + 1);
      end else if (n > 0) begin
        x = x + jitter(span); y = y + jitter(span); z = z + jitter(span);
      end
      hx.push_back(x); hy.push_back(y); hz.push_back(z);
      put_point(x, y, z, n == len - 1, quiet);
    end
    paths_sent++;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (loops_due_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic set_threshold(logic [15:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    int len, r;
    rst_n <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_point_x <= '0;
    in_point_y <= '0;
    in_point_z <= '0;
    in_is_last_point <= 1'b0;
    calm_out = 0;
    idle_cycles = 0;
    paths_sent = 0;
    points_sent = 0;
    settings_used = 1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed paths at the reset threshold: a crossing, a lone point, a short path,
    // collinear and repeated points, and full-scale diagonals.
    put_point(0, 0, 0, 0, 0);
    put_point(2048, 0, 0, 0, 0);
    put_point(2048, 2048, 0, 0, 0);
    put_point(1024, -1024, 0, 0, 0);
    put_point(0, 0, 512, 1, 0);
    put_point(24'sh7FFFFF, 24'sh800000, 24'sh7FFFFF, 1, 0);
    put_point(24'sh800000, 24'sh800000, 24'sh800000, 0, 0);
    put_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0);
    put_point(0, 0, 0, 1, 0);
    put_point(0, 0, 0, 0, 1);
    put_point(256, 0, 0, 0, 1);
    put_point(512, 0, 0, 0, 1);
    put_point(768, 0, 0, 0, 1);
    put_point(768, 0, 0, 1, 1);
    put_point(24'sh800000, 24'sh800000, 24'sh800000, 0, 0);
    put_point(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF, 0, 0);
    put_point(24'sh7FFFFF, 24'sh800000, 0, 0, 0);
    put_point(24'sh800000, 24'sh7FFFFF, 0, 1, 0);
    paths_sent += 5;

    // Widest threshold: a dense cluster fills the loop table, and an over-long one
    // also overflows the point store.
    set_threshold(16'hFFFF);
    send_path(36, 64, 0);
    send_path(260, 64, 0);
    send_path(6, 24'sh7FFFFF, 1);

    set_threshold(16'h0000);
    send_path(8, 512, 0);
    send_path(5, 0, 0);

    points_sent = 0;
    while (points_sent < RANDOM_POINTS) begin
      if ($urandom_range(0, 4) == 0) begin
        r = $urandom_range(0, 5);
        set_threshold(r == 0 ? 16'h0000 : r == 1 ? 16'hFFFF : 16'($urandom_range(16, 4096)));
      end
      r = $urandom_range(0, 99);
      len = (r < 80) ? $urandom_range(2, 12) : $urandom_range(13, 22);
      r = $urandom_range(0, 9);
      if (r == 0)      send_path(len, 0, 1);
      else if (r < 5)  send_path(len, 512, 0);
      else if (r < 8)  send_path(len, 4096, 0);
      else             send_path($urandom_range(1, 4), 2048, 0);
    end

    wait_idle();
    repeat (50) @(posedge clk);
    $display("Covered %0d paths over %0d threshold settings; %0d results checked.",
             paths_sent, settings_used, results_seen);
    if (fail_count == 0 && loops_due_count == 0)
      $display("path_loop_detector test passed");
    else
      $display("path_loop_detector test failed");
    $finish;
  end
endmodule
`default_nettype wire

/* files.f */
sv/pld_pkg.sv
sv/pld_front.sv
sv/pld_mul.sv
sv/pld_div.sv
sv/pld_back.sv
sv/path_loop_detector.sv
sim/pld_loop_checker.sv
sim/tb_path_loop_detector.sv
